>>> rtl/core/psc_pkg.sv
// Shared types, widths and constants of the potentiometer speed command block.
// No dependencies; used by psc_mul_div and pot_speed_command_ramp_unit.
package psc_pkg;

    localparam int SAMPLE_W = 12;
    localparam int AVG_W    = 12;
    localparam int SUM_W    = 21;
    localparam int OUT_W    = 15;
    localparam int TICK_W   = 16;
    localparam int PROD_W   = AVG_W + OUT_W;
    localparam int CNT_W    = $clog2(PROD_W);
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;

    localparam logic [TICK_W-1:0] TICKS_PER_UPDATE = 16'd10;
    localparam int                AVG_SHIFT        = 3;
    localparam logic [AVG_W-1:0]  SAMPLE_MAX       = 12'd4095;

    localparam logic [AVG_W-1:0] RST_DEAD_LOW  = 12'd1800;
    localparam logic [AVG_W-1:0] RST_DEAD_HIGH = 12'd2300;
    localparam logic [OUT_W-1:0] RST_PULSE_MIN = 15'd0;
    localparam logic [OUT_W-1:0] RST_PULSE_MAX = 15'd1000;
    localparam logic [OUT_W-1:0] RST_RPM_MIN   = 15'd0;
    localparam logic [OUT_W-1:0] RST_RPM_MAX   = 15'd3000;
    localparam logic [OUT_W-1:0] RST_RAMP_STEP = 15'd10;
    localparam logic [OUT_W-1:0] OUT_MAX       = 15'h7FFF;

    // register indexes (byte address / 4)
    localparam logic [2:0] REG_DEAD_LOW    = 3'd0;
    localparam logic [2:0] REG_DEAD_HIGH   = 3'd1;
    localparam logic [2:0] REG_PULSE_MIN   = 3'd2;
    localparam logic [2:0] REG_PULSE_MAX   = 3'd3;
    localparam logic [2:0] REG_RPM_MIN     = 3'd4;
    localparam logic [2:0] REG_RPM_MAX     = 3'd5;
    localparam logic [2:0] REG_RAMP_STEP   = 3'd6;
    localparam logic [2:0] REG_CLOSED_LOOP = 3'd7;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_AVG,
        ST_DECIDE,
        ST_MAP,
        ST_RAMP,
        ST_EMIT
    } psc_state_t;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_MUL,
        PH_DIV,
        PH_FIX,
        PH_DONE
    } psc_phase_t;

    // request to the serial map unit: lo + sign * (dx * mag) / span
    typedef struct packed {
        logic             start;
        logic             neg;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] mag;
        logic [AVG_W-1:0] dx;
        logic [AVG_W-1:0] span;
    } psc_md_req_t;

    typedef struct packed {
        logic             done;
        logic [OUT_W-1:0] target;
    } psc_md_rsp_t;

endpackage

>>> rtl/core/psc_mul_div.sv
// Bit-serial linear map unit: shift-add multiply, restoring divide, offset and clamp.
// Depends on psc_pkg for widths, the phase enum and the request/response structs.
module psc_mul_div (
    input  logic                  clk,
    input  logic                  rst_n,
    input  psc_pkg::psc_md_req_t  req,
    output psc_pkg::psc_md_rsp_t  rsp
);

    psc_pkg::psc_phase_t            phase_reg, phase_next;
    logic [psc_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic [psc_pkg::PROD_W-1:0]     acc_reg, acc_next;
    logic [psc_pkg::AVG_W-1:0]      rem_reg, rem_next;
    logic [psc_pkg::AVG_W-1:0]      mplier_reg, mplier_next;
    logic [psc_pkg::OUT_W-1:0]      mcand_reg, mcand_next;
    logic [psc_pkg::AVG_W-1:0]      div_reg, div_next;
    logic [psc_pkg::OUT_W-1:0]      lo_reg, lo_next;
    logic                           neg_reg, neg_next;
    logic [psc_pkg::OUT_W-1:0]      res_reg, res_next;

    logic [psc_pkg::AVG_W:0]        trial;
    logic [psc_pkg::AVG_W:0]        trial_sub;
    logic                           q_big;
    logic [psc_pkg::OUT_W-1:0]      q_lo;
    logic [psc_pkg::OUT_W:0]        pos_sum;
    logic [psc_pkg::OUT_W+1:0]      neg_diff;
    logic                           cnt_zero;

    assign cnt_zero = (cnt_reg == '0);

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            psc_pkg::PH_IDLE: if (req.start) phase_next = psc_pkg::PH_MUL;
            psc_pkg::PH_MUL:  if (cnt_zero) phase_next = psc_pkg::PH_DIV;
            psc_pkg::PH_DIV:  if (cnt_zero) phase_next = psc_pkg::PH_FIX;
            psc_pkg::PH_FIX:  phase_next = psc_pkg::PH_DONE;
            psc_pkg::PH_DONE: phase_next = psc_pkg::PH_IDLE;
            default:          phase_next = psc_pkg::PH_IDLE;
        endcase
    end

    always_comb
    begin
        rsp.done   = (phase_reg == psc_pkg::PH_DONE);
        rsp.target = res_reg;
    end

    // one restoring step: bring down the dividend msb, subtract if it fits
    assign trial     = {rem_reg, acc_reg[psc_pkg::PROD_W-1]};
    assign trial_sub = trial - {1'b0, div_reg};

    // quotient never exceeds 15 bits while the average stays within its range
    assign q_big    = |acc_reg[psc_pkg::PROD_W-1:psc_pkg::OUT_W];
    assign q_lo     = acc_reg[psc_pkg::OUT_W-1:0];
    assign pos_sum  = {1'b0, lo_reg} + {1'b0, q_lo};
    assign neg_diff = {2'b00, lo_reg} - {2'b00, q_lo};

    always_comb
    begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        rem_next    = rem_reg;
        mplier_next = mplier_reg;
        mcand_next  = mcand_reg;
        div_next    = div_reg;
        lo_next     = lo_reg;
        neg_next    = neg_reg;
        res_next    = res_reg;
        unique case (phase_reg)
            psc_pkg::PH_IDLE:
            begin
                if (req.start)
                begin
                    cnt_next    = psc_pkg::CNT_W'(psc_pkg::AVG_W - 1);
                    acc_next    = '0;
                    rem_next    = '0;
                    mplier_next = req.dx;
                    mcand_next  = req.mag;
                    div_next    = req.span;
                    lo_next     = req.lo;
                    neg_next    = req.neg;
                end
            end
            psc_pkg::PH_MUL:
            begin
                // msb first: double and add the multiplicand when the bit is set
                acc_next = {acc_reg[psc_pkg::PROD_W-2:0], 1'b0}
                    + (mplier_reg[psc_pkg::AVG_W-1]
                       ? {{(psc_pkg::PROD_W-psc_pkg::OUT_W){1'b0}}, mcand_reg}
                       : '0);
                mplier_next = {mplier_reg[psc_pkg::AVG_W-2:0], 1'b0};
                if (cnt_zero)
                    cnt_next = psc_pkg::CNT_W'(psc_pkg::PROD_W - 1);
                else
                    cnt_next = cnt_reg - 1'b1;
            end
            psc_pkg::PH_DIV:
            begin
                if (!trial_sub[psc_pkg::AVG_W])
                begin
                    rem_next = trial_sub[psc_pkg::AVG_W-1:0];
                    acc_next = {acc_reg[psc_pkg::PROD_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next = trial[psc_pkg::AVG_W-1:0];
                    acc_next = {acc_reg[psc_pkg::PROD_W-2:0], 1'b0};
                end
                cnt_next = cnt_reg - 1'b1;
            end
            psc_pkg::PH_FIX:
            begin
                // offset by the low bound and clamp to the 15-bit range
                if (neg_reg)
                    res_next = (q_big || neg_diff[psc_pkg::OUT_W+1])
                               ? '0 : neg_diff[psc_pkg::OUT_W-1:0];
                else
                    res_next = (q_big || pos_sum[psc_pkg::OUT_W])
                               ? psc_pkg::OUT_MAX : pos_sum[psc_pkg::OUT_W-1:0];
            end
            psc_pkg::PH_DONE:
            begin
                res_next = res_reg;
            end
            default:
            begin
                res_next = res_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= psc_pkg::PH_IDLE;
        else
            phase_reg <= phase_next;
    end

    always_ff @(posedge clk)
    begin
        cnt_reg    <= cnt_next;
        acc_reg    <= acc_next;
        rem_reg    <= rem_next;
        mplier_reg <= mplier_next;
        mcand_reg  <= mcand_next;
        div_reg    <= div_next;
        lo_reg     <= lo_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
    end

endmodule

>>> rtl/core/pot_speed_command_ramp_unit.sv
// Top level of the potentiometer speed command: prescaler, leaky average,
// dead band, linear map and pulse ramp. Depends on psc_pkg and psc_mul_div.
//
//   channel   handshake              payload
//   tick      tick_valid/tick_ready  sample, startup_done, power_on
//   cmd       cmd_valid/cmd_ready    pulse, direction, speed_reference,
//                                    running, stop_event, updated
//   config    APB psel/penable       paddr[4:2] selects the register, pwdata
//
// A tick without update goes to emit. An update passes the average state
// and, after startup, decide, which sends a dead-band update to emit, an
// empty input span to the ramp and the rest to the map unit, which runs the
// shift-add multiply and the restoring divide, one bit per cycle.
// Reset restores the config registers to defaults and the prescaler to
// its reload value. A held result waits in the output register; the next
// tick is taken meanwhile and its result waits until the register frees.
module pot_speed_command_ramp_unit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          tick_valid,
    output logic                          tick_ready,
    input  logic [psc_pkg::SAMPLE_W-1:0]  sample,
    input  logic                          startup_done,
    input  logic                          power_on,
    output logic                          cmd_valid,
    input  logic                          cmd_ready,
    output logic [psc_pkg::OUT_W-1:0]     pulse,
    output logic                          direction,
    output logic [psc_pkg::OUT_W-1:0]     speed_reference,
    output logic                          running,
    output logic                          stop_event,
    output logic                          updated,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [psc_pkg::ADDR_W-1:0]    paddr,
    input  logic [psc_pkg::DATA_W-1:0]    pwdata,
    output logic [psc_pkg::DATA_W-1:0]    prdata,
    output logic                          pready
);

    // configuration
    logic [psc_pkg::AVG_W-1:0] dead_low_reg, dead_high_reg;
    logic [psc_pkg::OUT_W-1:0] pulse_min_reg, pulse_max_reg;
    logic [psc_pkg::OUT_W-1:0] rpm_min_reg, rpm_max_reg, ramp_step_reg;
    logic                      closed_loop_reg;
    logic                      cfg_we;
    logic [2:0]                cfg_idx;

    // control state
    psc_pkg::psc_state_t       state_reg, state_next;
    logic [psc_pkg::TICK_W-1:0] tick_reg, tick_next;
    logic [psc_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [psc_pkg::AVG_W-1:0] avg_reg, avg_next;
    logic [psc_pkg::OUT_W-1:0] pulse_reg, pulse_next;
    logic                      dir_reg, dir_next;
    logic                      run_reg, run_next;
    logic [psc_pkg::OUT_W-1:0] ref_reg, ref_next;
    logic                      stop_reg, stop_next;
    logic                      upd_reg, upd_next;
    logic                      cmd_valid_reg, cmd_valid_next;

    // per-item payload
    logic [psc_pkg::SAMPLE_W-1:0] sample_reg, sample_next;
    logic                      startup_reg, startup_next;
    logic                      power_reg, power_next;
    logic [psc_pkg::OUT_W-1:0] target_reg, target_next;
    logic [psc_pkg::OUT_W-1:0] pulse_out_reg, pulse_out_next;
    logic                      dir_out_reg, dir_out_next;
    logic [psc_pkg::OUT_W-1:0] ref_out_reg, ref_out_next;
    logic                      run_out_reg, run_out_next;
    logic                      stop_out_reg, stop_out_next;
    logic                      upd_out_reg, upd_out_next;

    // decision and ramp terms
    logic [psc_pkg::TICK_W-1:0] tick_dec;
    logic                      in_band, use_cw;
    logic [psc_pkg::OUT_W-1:0] lo_sel, hi_sel, mag_sel;
    logic                      out_neg;
    logic [psc_pkg::AVG_W:0]   cw_diff;
    logic [psc_pkg::AVG_W-1:0] span_sel, dx_sel;
    logic                      span_empty;
    logic [psc_pkg::OUT_W-1:0] up_diff, down_diff;
    logic                      out_load;
    logic                      md_start;

    psc_pkg::psc_md_req_t      md_req;
    psc_pkg::psc_md_rsp_t      md_rsp;

    // ---------------- configuration port ----------------
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite;
    assign cfg_idx = paddr[psc_pkg::ADDR_W-1:2];

    always_comb
    begin
        prdata = '0;
        unique case (cfg_idx)
            psc_pkg::REG_DEAD_LOW:    prdata = {20'd0, dead_low_reg};
            psc_pkg::REG_DEAD_HIGH:   prdata = {20'd0, dead_high_reg};
            psc_pkg::REG_PULSE_MIN:   prdata = {17'd0, pulse_min_reg};
            psc_pkg::REG_PULSE_MAX:   prdata = {17'd0, pulse_max_reg};
            psc_pkg::REG_RPM_MIN:     prdata = {17'd0, rpm_min_reg};
            psc_pkg::REG_RPM_MAX:     prdata = {17'd0, rpm_max_reg};
            psc_pkg::REG_RAMP_STEP:   prdata = {17'd0, ramp_step_reg};
            psc_pkg::REG_CLOSED_LOOP: prdata = {31'd0, closed_loop_reg};
            default:                  prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_low_reg    <= psc_pkg::RST_DEAD_LOW;
            dead_high_reg   <= psc_pkg::RST_DEAD_HIGH;
            pulse_min_reg   <= psc_pkg::RST_PULSE_MIN;
            pulse_max_reg   <= psc_pkg::RST_PULSE_MAX;
            rpm_min_reg     <= psc_pkg::RST_RPM_MIN;
            rpm_max_reg     <= psc_pkg::RST_RPM_MAX;
            ramp_step_reg   <= psc_pkg::RST_RAMP_STEP;
            closed_loop_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                psc_pkg::REG_DEAD_LOW:    dead_low_reg    <= pwdata[psc_pkg::AVG_W-1:0];
                psc_pkg::REG_DEAD_HIGH:   dead_high_reg   <= pwdata[psc_pkg::AVG_W-1:0];
                psc_pkg::REG_PULSE_MIN:   pulse_min_reg   <= pwdata[psc_pkg::OUT_W-1:0];
                psc_pkg::REG_PULSE_MAX:   pulse_max_reg   <= pwdata[psc_pkg::OUT_W-1:0];
                psc_pkg::REG_RPM_MIN:     rpm_min_reg     <= pwdata[psc_pkg::OUT_W-1:0];
                psc_pkg::REG_RPM_MAX:     rpm_max_reg     <= pwdata[psc_pkg::OUT_W-1:0];
                psc_pkg::REG_RAMP_STEP:   ramp_step_reg   <= pwdata[psc_pkg::OUT_W-1:0];
                psc_pkg::REG_CLOSED_LOOP: closed_loop_reg <= pwdata[0];
                default:                  closed_loop_reg <= closed_loop_reg;
            endcase
        end
    end

    // ---------------- decision terms ----------------
    assign tick_dec = tick_reg - 1'b1;

    always_comb
    begin
        in_band = (avg_reg > dead_low_reg) && (avg_reg < dead_high_reg);
        // where both range tests pass, the clockwise half wins
        use_cw  = (avg_reg >= dead_high_reg);
        lo_sel  = closed_loop_reg ? rpm_min_reg : pulse_min_reg;
        hi_sel  = closed_loop_reg ? rpm_max_reg : pulse_max_reg;
        out_neg = (hi_sel < lo_sel);
        mag_sel = out_neg ? (lo_sel - hi_sel) : (hi_sel - lo_sel);
        cw_diff = {1'b0, psc_pkg::SAMPLE_MAX} - {1'b0, dead_high_reg};
        if (use_cw)
        begin
            span_sel   = cw_diff[psc_pkg::AVG_W-1:0];
            span_empty = cw_diff[psc_pkg::AVG_W] || (cw_diff == '0);
            dx_sel     = avg_reg - dead_high_reg;
        end
        else
        begin
            span_sel   = dead_low_reg;
            span_empty = (dead_low_reg == '0);
            dx_sel     = avg_reg;
        end
        up_diff   = target_reg - pulse_reg;
        down_diff = pulse_reg - target_reg;
    end

    assign md_req.start = md_start;
    assign md_req.neg   = out_neg;
    assign md_req.lo    = lo_sel;
    assign md_req.mag   = mag_sel;
    assign md_req.dx    = dx_sel;
    assign md_req.span  = span_sel;

    psc_mul_div u_mul_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (md_req),
        .rsp   (md_rsp)
    );

    // ---------------- state machine ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            psc_pkg::ST_IDLE:
                if (tick_valid)
                    state_next = (tick_dec == '0) ? psc_pkg::ST_AVG : psc_pkg::ST_EMIT;
            psc_pkg::ST_AVG:
                state_next = startup_reg ? psc_pkg::ST_DECIDE : psc_pkg::ST_EMIT;
            psc_pkg::ST_DECIDE:
                if (in_band)
                    state_next = psc_pkg::ST_EMIT;
                else if (span_empty)
                    state_next = psc_pkg::ST_RAMP;
                else
                    state_next = psc_pkg::ST_MAP;
            psc_pkg::ST_MAP:
                if (md_rsp.done)
                    state_next = psc_pkg::ST_RAMP;
            psc_pkg::ST_RAMP:
                state_next = psc_pkg::ST_EMIT;
            psc_pkg::ST_EMIT:
                if (out_load)
                    state_next = psc_pkg::ST_IDLE;
            default:
                state_next = psc_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        tick_ready = (state_reg == psc_pkg::ST_IDLE);
        md_start   = (state_reg == psc_pkg::ST_DECIDE) && !in_band && !span_empty;
        out_load   = (state_reg == psc_pkg::ST_EMIT) && (!cmd_valid_reg || cmd_ready);
    end

    // ---------------- datapath ----------------
    always_comb
    begin
        tick_next      = tick_reg;
        sum_next       = sum_reg;
        avg_next       = avg_reg;
        pulse_next     = pulse_reg;
        dir_next       = dir_reg;
        run_next       = run_reg;
        ref_next       = ref_reg;
        stop_next      = stop_reg;
        upd_next       = upd_reg;
        sample_next    = sample_reg;
        startup_next   = startup_reg;
        power_next     = power_reg;
        target_next    = target_reg;
        pulse_out_next = pulse_out_reg;
        dir_out_next   = dir_out_reg;
        ref_out_next   = ref_out_reg;
        run_out_next   = run_out_reg;
        stop_out_next  = stop_out_reg;
        upd_out_next   = upd_out_reg;

        unique case (state_reg)
            psc_pkg::ST_IDLE:
            begin
                if (tick_valid)
                begin
                    sample_next  = sample;
                    startup_next = startup_done;
                    power_next   = power_on;
                    stop_next    = 1'b0;
                    upd_next     = (tick_dec == '0);
                    tick_next    = (tick_dec == '0) ? psc_pkg::TICKS_PER_UPDATE : tick_dec;
                end
            end
            psc_pkg::ST_AVG:
            begin
                sum_next = sum_reg - {{(psc_pkg::SUM_W-psc_pkg::AVG_W){1'b0}}, avg_reg}
                         + {{(psc_pkg::SUM_W-psc_pkg::SAMPLE_W){1'b0}}, sample_reg};
                avg_next = sum_next[psc_pkg::AVG_SHIFT +: psc_pkg::AVG_W];
            end
            psc_pkg::ST_DECIDE:
            begin
                if (in_band)
                begin
                    stop_next = run_reg;
                    run_next  = 1'b0;
                end
                else
                begin
                    run_next    = power_reg;
                    dir_next    = use_cw;
                    // empty input span maps to the low bound
                    target_next = lo_sel;
                end
            end
            psc_pkg::ST_MAP:
            begin
                if (md_rsp.done)
                    target_next = md_rsp.target;
            end
            psc_pkg::ST_RAMP:
            begin
                if (closed_loop_reg)
                    ref_next = target_reg;
                else if (target_reg > pulse_reg)
                    pulse_next = (ramp_step_reg < up_diff) ? (pulse_reg + ramp_step_reg)
                                                           : target_reg;
                else if (target_reg < pulse_reg)
                    pulse_next = (ramp_step_reg < down_diff) ? (pulse_reg - ramp_step_reg)
                                                             : target_reg;
            end
            psc_pkg::ST_EMIT:
            begin
                if (out_load)
                begin
                    pulse_out_next = pulse_reg;
                    dir_out_next   = dir_reg;
                    ref_out_next   = ref_reg;
                    run_out_next   = run_reg;
                    stop_out_next  = stop_reg;
                    upd_out_next   = upd_reg;
                end
            end
            default:
            begin
                tick_next = tick_reg;
            end
        endcase
    end

    always_comb
    begin
        if (out_load)
            cmd_valid_next = 1'b1;
        else if (cmd_ready)
            cmd_valid_next = 1'b0;
        else
            cmd_valid_next = cmd_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= psc_pkg::ST_IDLE;
            tick_reg      <= psc_pkg::TICKS_PER_UPDATE;
            sum_reg       <= '0;
            avg_reg       <= '0;
            pulse_reg     <= '0;
            dir_reg       <= 1'b0;
            run_reg       <= 1'b0;
            ref_reg       <= '0;
            stop_reg      <= 1'b0;
            upd_reg       <= 1'b0;
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tick_reg      <= tick_next;
            sum_reg       <= sum_next;
            avg_reg       <= avg_next;
            pulse_reg     <= pulse_next;
            dir_reg       <= dir_next;
            run_reg       <= run_next;
            ref_reg       <= ref_next;
            stop_reg      <= stop_next;
            upd_reg       <= upd_next;
            cmd_valid_reg <= cmd_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sample_reg    <= sample_next;
        startup_reg   <= startup_next;
        power_reg     <= power_next;
        target_reg    <= target_next;
        pulse_out_reg <= pulse_out_next;
        dir_out_reg   <= dir_out_next;
        ref_out_reg   <= ref_out_next;
        run_out_reg   <= run_out_next;
        stop_out_reg  <= stop_out_next;
        upd_out_reg   <= upd_out_next;
    end

    assign cmd_valid       = cmd_valid_reg;
    assign pulse           = pulse_out_reg;
    assign direction       = dir_out_reg;
    assign speed_reference = ref_out_reg;
    assign running         = run_out_reg;
    assign stop_event      = stop_out_reg;
    assign updated         = upd_out_reg;

`ifndef SYNTH
    // a stop item always reports a stopped motor on an update tick
    a_stop_means_stopped: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && stop_event) |-> (!running && updated))
        else $error("stop item without a stopped update");

    // the map unit answers only while the sequencer waits for it
    a_done_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        md_rsp.done |-> (state_reg == psc_pkg::ST_MAP))
        else $error("map unit finished outside the map state");

    // a tick that leaves the prescaler running goes straight to its result
    a_plain_tick: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == psc_pkg::ST_IDLE && tick_valid && tick_reg != 16'd1)
        |=> (state_reg == psc_pkg::ST_EMIT && !upd_reg))
        else $error("tick without update did not go to emit");
`endif

endmodule

>>> sim/pot_speed_command_ramp_unit_tb.sv
// Testbench for pot_speed_command_ramp_unit: sends ticks in bursts with random gaps, stalls the
// command channel and checks each command against an in-bench speed command model.
// Depends on psc_pkg and the RTL of pot_speed_command_ramp_unit.
module pot_speed_command_ramp_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psc_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_TICKS   = 54;
    localparam int SETTLE_CYCLES = 60;

    typedef struct packed {
        logic [OUT_W-1:0] pulse;
        logic             direction;
        logic [OUT_W-1:0] speed_reference;
        logic             running;
        logic             stop_event;
        logic             updated;
    } command_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] smp;
        logic                startup;
        logic                power;
        logic                running;
        logic                updated;
    } opening_tick_t;

    typedef struct packed {
        logic [AVG_W-1:0] low_edge;
        logic [AVG_W-1:0] high_edge;
        logic [OUT_W-1:0] pulse_lo;
        logic [OUT_W-1:0] pulse_hi;
        logic [OUT_W-1:0] rpm_lo;
        logic [OUT_W-1:0] rpm_hi;
        logic [OUT_W-1:0] slew;
        logic             closed;
    } ramp_cfg_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                tick_valid = 1'b0;
    logic                tick_ready;
    logic [SAMPLE_W-1:0] sample = '0;
    logic                startup_done = 1'b0;
    logic                power_on = 1'b0;
    logic                cmd_valid;
    logic                cmd_ready = 1'b0;
    logic [OUT_W-1:0]    pulse;
    logic                direction;
    logic [OUT_W-1:0]    speed_reference;
    logic                running;
    logic                stop_event;
    logic                updated;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    // model state of the speed command
    logic [TICK_W-1:0] tick_left = TICKS_PER_UPDATE;
    logic [SUM_W-1:0]  level_sum = '0;
    logic [AVG_W-1:0]  level_avg = '0;
    logic [OUT_W-1:0]  held_pulse = '0;
    logic              held_dir = 1'b0;
    logic              held_run = 1'b0;
    logic [OUT_W-1:0]  held_reference = '0;
    ramp_cfg_t live_cfg = '{RST_DEAD_LOW, RST_DEAD_HIGH, RST_PULSE_MIN, RST_PULSE_MAX,
                            RST_RPM_MIN, RST_RPM_MAX, RST_RAMP_STEP, 1'b0};

    command_t due_commands[$];
    int       mismatches = 0;
    int       burst_left = 0;
    int       ready_mode = 0;
    int       ready_left = 0;
    int       quiet_cycles = 0;

    // ticks right after reset: every field is zero except running and updated
    opening_tick_t opening_ticks [22] = '{
        '{12'hFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'h000, 1'b0, 1'b0, 1'b0, 1'b0},
        '{12'hAAA, 1'b1, 1'b0, 1'b0, 1'b0},
        '{12'h555, 1'b0, 1'b1, 1'b0, 1'b0},
        '{12'hFFF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{12'h000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'h800, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'h001, 1'b0, 1'b1, 1'b0, 1'b0},
        '{12'hFFE, 1'b1, 1'b0, 1'b0, 1'b0},
        // update before startup: average only
        '{12'h000, 1'b0, 1'b1, 1'b0, 1'b1},
        '{12'hFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'hAAA, 1'b0, 1'b1, 1'b0, 1'b0},
        '{12'h555, 1'b1, 1'b0, 1'b0, 1'b0},
        '{12'h000, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'h7FF, 1'b0, 1'b0, 1'b0, 1'b0},
        '{12'hFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        '{12'h0F0, 1'b1, 1'b0, 1'b0, 1'b0},
        '{12'hF0F, 1'b0, 1'b1, 1'b0, 1'b0},
        '{12'hFFF, 1'b1, 1'b1, 1'b0, 1'b0},
        // zero average maps to a zero target: run with the pulse held at zero
        '{12'h000, 1'b1, 1'b1, 1'b1, 1'b1},
        '{12'hFFF, 1'b1, 1'b0, 1'b1, 1'b0},
        '{12'hAAA, 1'b0, 1'b0, 1'b1, 1'b0}
    };

    pot_speed_command_ramp_unit dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .tick_valid      (tick_valid),
        .tick_ready      (tick_ready),
        .sample          (sample),
        .startup_done    (startup_done),
        .power_on        (power_on),
        .cmd_valid       (cmd_valid),
        .cmd_ready       (cmd_ready),
        .pulse           (pulse),
        .direction       (direction),
        .speed_reference (speed_reference),
        .running         (running),
        .stop_event      (stop_event),
        .updated         (updated),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic logic [OUT_W-1:0] map_span(input longint x, input longint in_lo,
                                                  input longint in_hi, input longint out_lo,
                                                  input longint out_hi);
        longint span_in;
        longint r;
        span_in = in_hi - in_lo;
        if (span_in <= 0)
            return out_lo[OUT_W-1:0];
        r = (x - in_lo) * (out_hi - out_lo) / span_in + out_lo;
        if (r < 0)
            r = 0;
        if (r > longint'(OUT_MAX))
            r = longint'(OUT_MAX);
        return r[OUT_W-1:0];
    endfunction

    function automatic command_t advance_speed_command(input logic [SAMPLE_W-1:0] smp,
                                                       input logic su, input logic pw);
        command_t         r;
        logic [OUT_W-1:0] lo;
        logic [OUT_W-1:0] hi;
        logic [OUT_W-1:0] target;
        logic [OUT_W-1:0] diff;
        r = '0;
        tick_left = tick_left - 1'b1;
        if (tick_left == '0)
        begin
            r.updated = 1'b1;
            tick_left = TICKS_PER_UPDATE;
            level_sum = level_sum - SUM_W'(level_avg) + SUM_W'(smp);
            level_avg = AVG_W'(level_sum >> AVG_SHIFT);
            if (su)
            begin
                if (level_avg > live_cfg.low_edge && level_avg < live_cfg.high_edge)
                begin
                    r.stop_event = held_run;
                    held_run = 1'b0;
                end
                else
                begin
                    lo = live_cfg.closed ? live_cfg.rpm_lo : live_cfg.pulse_lo;
                    hi = live_cfg.closed ? live_cfg.rpm_hi : live_cfg.pulse_hi;
                    target = '0;
                    held_run = pw;
                    if (level_avg <= live_cfg.low_edge)
                    begin
                        target = map_span(longint'(level_avg), 0,
                                          longint'(live_cfg.low_edge),
                                          longint'(lo), longint'(hi));
                        held_dir = 1'b0;
                    end
                    // overlapping ranges: the CW half wins
                    if (level_avg >= live_cfg.high_edge)
                    begin
                        target = map_span(longint'(level_avg), longint'(live_cfg.high_edge),
                                          longint'(SAMPLE_MAX),
                                          longint'(lo), longint'(hi));
                        held_dir = 1'b1;
                    end
                    if (live_cfg.closed)
                        held_reference = target;
                    else if (target > held_pulse)
                    begin
                        diff = target - held_pulse;
                        held_pulse = held_pulse + ((live_cfg.slew < diff) ? live_cfg.slew : diff);
                    end
                    else if (target < held_pulse)
                    begin
                        diff = held_pulse - target;
                        held_pulse = held_pulse - ((live_cfg.slew < diff) ? live_cfg.slew : diff);
                    end
                end
            end
        end
        r.pulse = held_pulse;
        r.direction = held_dir;
        r.speed_reference = held_reference;
        r.running = held_run;
        return r;
    endfunction

    task automatic compare_field(input string field, input logic [OUT_W-1:0] want,
                                 input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, got %0d", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic send_tick(input logic [SAMPLE_W-1:0] smp, input logic su, input logic pw,
                             input logic typed, input command_t typed_cmd);
        command_t predicted;
        int       gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap != 0)
            begin
                tick_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        tick_valid <= 1'b1;
        sample <= smp;
        startup_done <= su;
        power_on <= pw;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        burst_left--;
        predicted = advance_speed_command(smp, su, pw);
        due_commands.push_back(typed ? typed_cmd : predicted);
    endtask

    // drop valid and hold until every command has come back
    task automatic drain_commands();
        tick_valid <= 1'b0;
        burst_left = 0;
        while (due_commands.size() != 0)
            @(posedge clk);
    endtask

    // psel stays high across back-to-back writes; the caller closes the transfer
    task automatic write_register(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
    endtask

    task automatic apply_cfg(input ramp_cfg_t c);
        write_register(REG_DEAD_LOW, DATA_W'(c.low_edge));
        write_register(REG_DEAD_HIGH, DATA_W'(c.high_edge));
        write_register(REG_PULSE_MIN, DATA_W'(c.pulse_lo));
        write_register(REG_PULSE_MAX, DATA_W'(c.pulse_hi));
        write_register(REG_RPM_MIN, DATA_W'(c.rpm_lo));
        write_register(REG_RPM_MAX, DATA_W'(c.rpm_hi));
        write_register(REG_RAMP_STEP, DATA_W'(c.slew));
        write_register(REG_CLOSED_LOOP, DATA_W'(c.closed));
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        live_cfg = c;
    endtask

    // hold the knob near one level per segment (random in some) so the average settles into a region
    task automatic run_segments(input int count, input bit zeros_first);
        int   sent;
        int   seg_len;
        int   kind;
        int   lvl;
        int   dl;
        int   dh;
        int   val;
        logic su;
        logic pw;
        sent = 0;
        while (sent < count)
        begin
            dl = int'(live_cfg.low_edge);
            dh = int'(live_cfg.high_edge);
            seg_len = $urandom_range(10, 50);
            su = ($urandom_range(0, 7) != 0);
            pw = ($urandom_range(0, 3) != 0);
            kind = $urandom_range(0, 5);
            if (zeros_first && sent == 0)
            begin
                kind = 3;
                su = 1'b1;
                pw = 1'b1;
            end
            case (kind)
                0: lvl = $urandom_range(0, dl);
                1: lvl = (dh > dl + 1) ? $urandom_range(dl + 1, dh - 1) : $urandom_range(0, 4095);
                2: lvl = $urandom_range(dh, 4095);
                3: lvl = 0;
                4: lvl = 4095;
                default: lvl = 0;
            endcase
            for (int k = 0; k < seg_len && sent < count; k++)
            begin
                if (kind == 5)
                    val = $urandom_range(0, 4095);
                else if (kind == 3 || $urandom_range(0, 1) == 0)
                    val = lvl;
                else
                    val = lvl + int'($urandom_range(0, 6)) - 3;
                if (val < 0)
                    val = 0;
                if (val > 4095)
                    val = 4095;
                send_tick(val[SAMPLE_W-1:0], su, pw, 1'b0, '0);
                sent++;
            end
        end
    endtask

    always @(posedge clk)
    begin : command_sink
        command_t seen;
        command_t want;
        if (rst_n && cmd_valid && cmd_ready)
        begin
            seen = {pulse, direction, speed_reference, running, stop_event, updated};
            if (due_commands.size() == 0)
            begin
                $display("%0t ns: command with no tick pending, expected none, got pulse %0d",
                         $time, seen.pulse);
                mismatches++;
            end
            else
            begin
                want = due_commands.pop_front();
                compare_field("pulse", want.pulse, seen.pulse);
                compare_field("direction", OUT_W'(want.direction), OUT_W'(seen.direction));
                compare_field("speed_reference", want.speed_reference, seen.speed_reference);
                compare_field("running", OUT_W'(want.running), OUT_W'(seen.running));
                compare_field("stop_event", OUT_W'(want.stop_event), OUT_W'(seen.stop_event));
                compare_field("updated", OUT_W'(want.updated), OUT_W'(seen.updated));
            end
        end
        if (ready_left == 0)
        begin
            ready_mode = $urandom_range(0, 3);
            ready_left = $urandom_range(20, 200);
        end
        else
            ready_left--;
        case (ready_mode)
            0: cmd_ready <= 1'b1;
            1: cmd_ready <= 1'($urandom_range(0, 1));
            2: cmd_ready <= ($urandom_range(0, 7) != 0);
            default: cmd_ready <= ((ready_left % 16) >= 12);
        endcase
    end

    always @(posedge clk)
    begin
        if ((tick_valid && tick_ready) || (cmd_valid && cmd_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("FAILURE");
        $finish;
    end

    initial
    begin : stimulus
        ramp_cfg_t next_cfg;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (opening_ticks[i])
            send_tick(opening_ticks[i].smp, opening_ticks[i].startup, opening_ticks[i].power,
                      1'b1, {15'd0, 1'b0, 15'd0, opening_ticks[i].running, 1'b0,
                             opening_ticks[i].updated});
        for (int phase = 0; phase < PHASE_COUNT; phase++)
        begin
            drain_commands();
            case (phase)
                // empty input spans on both halves while the average still sits at zero
                0: next_cfg = '{12'd0, 12'd4095, 15'd777, 15'd32767, RST_RPM_MIN, RST_RPM_MAX,
                                15'd32767, 1'b0};
                1: next_cfg = '{RST_DEAD_LOW, RST_DEAD_HIGH, RST_PULSE_MIN, RST_PULSE_MAX,
                                RST_RPM_MIN, RST_RPM_MAX, RST_RAMP_STEP, 1'b0};
                2: next_cfg = '{12'd1, 12'd4094, 15'd5, 15'd9, 15'd0, 15'd32767, 15'd1, 1'b1};
                // overlapping ranges, falling map
                3: next_cfg = '{12'd4094, 12'd1, 15'd32767, 15'd0, 15'd100, 15'd200,
                                15'd32767, 1'b0};
                4: next_cfg = '{12'd2048, 12'd2048, 15'd0, 15'd0, 15'd32767, 15'd0, 15'd0, 1'b1};
                // zero step freezes the pulse
                5: next_cfg = '{12'd1000, 12'd3000, 15'd0, 15'd32767, 15'd0, 15'd0, 15'd0, 1'b0};
                default:
                begin
                    next_cfg.low_edge = AVG_W'($urandom_range(0, 4095));
                    next_cfg.high_edge = AVG_W'($urandom_range(0, 4095));
                    next_cfg.pulse_lo = OUT_W'($urandom_range(0, 32767));
                    next_cfg.pulse_hi = OUT_W'($urandom_range(0, 32767));
                    next_cfg.rpm_lo = OUT_W'($urandom_range(0, 32767));
                    next_cfg.rpm_hi = OUT_W'($urandom_range(0, 32767));
                    next_cfg.slew = OUT_W'($urandom_range(0, 32767));
                    next_cfg.closed = 1'($urandom_range(0, 1));
                end
            endcase
            apply_cfg(next_cfg);
            run_segments(PHASE_TICKS, phase == 0);
        end
        drain_commands();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
